@@ src/kul_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_pkg: shared types and constants of the keyed list table
// Field widths, operation and status codes, and the command word that
// travels from the front end through the queue to the back end.
// ---------------------------------------------------------------------------
package kul_pkg;

    // field widths
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    // defaults
    localparam int MAX_ENTRIES_DEF     = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    // operations, encoded as the request mode
    typedef enum logic [MODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FIRST = 3'd2,
        OP_REM_LAST  = 3'd3,
        OP_REM_KEY   = 3'd4,
        OP_FIND_KEY  = 3'd5,
        OP_UPD_KEY   = 3'd6,
        OP_NOP       = 3'd7
    } t_op;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // decoded command word
    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] entry_key;
        logic [PAY_W-1:0]        entry_payload;
    } t_cmd;

endpackage
`default_nettype wire

@@ src/kul_req_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_req_if: request channel
// Valid/ready channel carrying one request word: mode, key and payload.
// ---------------------------------------------------------------------------
interface kul_req_if;
    import kul_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0]        entry_payload;

    modport source (output valid, output mode, output entry_key, output entry_payload,
                    input ready);
    modport sink   (input valid, input mode, input entry_key, input entry_payload,
                    output ready);
endinterface
`default_nettype wire

@@ src/kul_rsp_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_rsp_if: result channel
// Valid/ready channel carrying one result word per request.
// ---------------------------------------------------------------------------
interface kul_rsp_if;
    import kul_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [PAY_W-1:0]   found_payload;
    logic [COUNT_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;

    modport source (output valid, output status, output found_payload,
                    output entry_count, output is_full, output is_empty, input ready);
    modport sink   (input valid, input status, input found_payload,
                    input entry_count, input is_full, input is_empty, output ready);
endinterface
`default_nettype wire

@@ src/kul_cfg_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_cfg_if: configuration write channel
// Valid/ready channel carrying the capacity limit register value.
// ---------------------------------------------------------------------------
interface kul_cfg_if;
    import kul_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface
`default_nettype wire

@@ src/kul_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_front: request front end
// Accepts request words while the queue has room and decodes the mode into
// an operation code for the back end.
// ---------------------------------------------------------------------------
module kul_front (
    kul_req_if.sink        i_req,
    input  wire logic      i_q_full,
    output logic           o_push,
    output kul_pkg::t_cmd  o_cmd
);
    import kul_pkg::*;

    // accept whenever the queue can take the word
    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    // mode decode; every mode value maps onto its operation, 7 is the no-op
    always_comb begin
        o_cmd.entry_key     = i_req.entry_key;
        o_cmd.entry_payload = i_req.entry_payload;
        o_cmd.op            = t_op'(i_req.mode);
    end
endmodule
`default_nettype wire

@@ src/kul_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_queue: command queue
// Short FIFO of decoded commands between the front and back ends.
// ---------------------------------------------------------------------------
module kul_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  kul_pkg::t_cmd       i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output kul_pkg::t_cmd       o_cmd,
    input  wire logic           i_pop
);
    import kul_pkg::*;

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

@@ src/kul_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kul_back: list back end
// Holds the key and payload stores and the entry count. A sequencer walks
// the stores one entry per cycle to shift, search and close gaps, then
// loads the result word into the output register.
// ---------------------------------------------------------------------------
module kul_back #(
    parameter int MAX_ENTRIES = kul_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [kul_pkg::CAP_W-1:0] i_capacity,
    input  wire logic                   i_q_valid,
    input  kul_pkg::t_cmd               i_q_cmd,
    output logic                        o_q_pop,
    kul_rsp_if.source                   o_rsp
);
    import kul_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOVE = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // stores
    logic signed [KEY_W-1:0] key_mem [MAX_ENTRIES];
    logic [PAY_W-1:0]        pay_mem [MAX_ENTRIES];
    logic signed [KEY_W-1:0] r_rd_key;
    logic [PAY_W-1:0]        r_rd_pay;

    logic [1:0]         r_state,  n_state;
    t_cmd               r_cmd,    n_cmd;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [IDX_W-1:0]   r_src,    n_src;
    logic [IDX_W-1:0]   r_dst,    n_dst;
    logic [CNT_W-1:0]   r_left,   n_left;
    logic               r_up,     n_up;
    logic               r_mv_v,   n_mv_v;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [PAY_W-1:0]   r_found,  n_found;
    logic [IDX_W-1:0]   r_pos,    n_pos;

    logic               r_out_valid,  n_out_valid;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [PAY_W-1:0]   r_out_found,  n_out_found;
    logic [COUNT_W-1:0] r_out_count,  n_out_count;
    logic               r_out_full,   n_out_full;
    logic               r_out_empty,  n_out_empty;

    logic [CMP_W-1:0]   eff_cap;
    logic               cur_full;
    logic [CNT_W-1:0]   fin_count;
    logic               hit;
    logic               we_key;
    logic               we_pay;
    logic [IDX_W-1:0]   waddr;
    logic signed [KEY_W-1:0] wkey;
    logic [PAY_W-1:0]   wpay;

    // capacity in effect saturates at the built depth
    assign eff_cap  = (CMP_W'(i_capacity) > CMP_W'(MAX_ENTRIES)) ?
                      CMP_W'(MAX_ENTRIES) : CMP_W'(i_capacity);
    assign cur_full = (CMP_W'(r_count) >= eff_cap);
    assign hit      = r_mv_v && (r_rd_key == r_cmd.entry_key);

    // count after the current command
    always_comb begin
        fin_count = r_count;
        if (r_status == ST_OK) begin
            case (r_cmd.op)
                OP_INS_FRONT, OP_INS_BACK: fin_count = r_count + CNT_W'(1);
                OP_REM_FIRST, OP_REM_LAST, OP_REM_KEY: fin_count = r_count - CNT_W'(1);
                default: fin_count = r_count;
            endcase
        end
    end

    // store write port
    always_comb begin
        we_key = 1'b0;
        we_pay = 1'b0;
        waddr  = r_dst;
        wkey   = r_rd_key;
        wpay   = r_rd_pay;
        if (r_state == S_MOVE && r_mv_v) begin
            we_key = 1'b1;
            we_pay = 1'b1;
        end else if (r_state == S_FIN && r_status == ST_OK) begin
            wkey = r_cmd.entry_key;
            wpay = r_cmd.entry_payload;
            case (r_cmd.op)
                OP_INS_FRONT: begin
                    we_key = 1'b1;
                    we_pay = 1'b1;
                    waddr  = '0;
                end
                OP_INS_BACK: begin
                    we_key = 1'b1;
                    we_pay = 1'b1;
                    waddr  = IDX_W'(r_count);
                end
                OP_UPD_KEY: begin
                    we_pay = 1'b1;
                    waddr  = r_pos;
                end
                default: begin
                    we_key = 1'b0;
                end
            endcase
        end
    end

    // stores: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we_key) begin
            key_mem[waddr] <= wkey;
        end
        if (we_pay) begin
            pay_mem[waddr] <= wpay;
        end
        r_rd_key <= key_mem[r_src];
        r_rd_pay <= pay_mem[r_src];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_src        = r_src;
        n_dst        = r_dst;
        n_left       = r_left;
        n_up         = r_up;
        n_mv_v       = r_mv_v;
        n_status     = r_status;
        n_found      = r_found;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        n_out_full   = r_out_full;
        n_out_empty  = r_out_empty;
        o_q_pop      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && (!r_out_valid || o_rsp.ready)) begin
                    o_q_pop  = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_mv_v   = 1'b0;
                    n_state  = S_FIN;
                    case (i_q_cmd.op)
                        OP_INS_FRONT: begin
                            if (cur_full) begin
                                n_status = ST_FULL;
                            end else begin
                                // shift every entry up by one, top first
                                n_src   = IDX_W'(r_count - CNT_W'(1));
                                n_left  = r_count;
                                n_up    = 1'b1;
                                n_state = S_MOVE;
                            end
                        end
                        OP_INS_BACK: begin
                            if (cur_full) begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_REM_FIRST: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_src   = IDX_W'(1);
                                n_left  = r_count - CNT_W'(1);
                                n_up    = 1'b0;
                                n_state = S_MOVE;
                            end
                        end
                        OP_REM_LAST: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        OP_REM_KEY, OP_FIND_KEY, OP_UPD_KEY: begin
                            n_src   = '0;
                            n_left  = r_count;
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_MOVE: begin
                // read one entry a cycle and write it from the registered read
                if (r_left != '0) begin
                    n_src  = r_up ? (r_src - IDX_W'(1)) : (r_src + IDX_W'(1));
                    n_dst  = r_up ? (r_src + IDX_W'(1)) : (r_src - IDX_W'(1));
                    n_left = r_left - CNT_W'(1);
                    n_mv_v = 1'b1;
                end else begin
                    n_mv_v  = 1'b0;
                    n_state = S_FIN;
                end
            end

            S_SRCH: begin
                // compare the entry read last cycle while reading the next
                if (hit) begin
                    n_mv_v = 1'b0;
                    case (r_cmd.op)
                        OP_FIND_KEY: begin
                            n_found = r_rd_pay;
                            n_state = S_FIN;
                        end
                        OP_UPD_KEY: begin
                            n_pos   = r_dst;
                            n_state = S_FIN;
                        end
                        default: begin
                            // close the gap above the match
                            n_src   = r_dst + IDX_W'(1);
                            n_left  = r_count - CNT_W'(1) - CNT_W'(r_dst);
                            n_up    = 1'b0;
                            n_state = S_MOVE;
                        end
                    endcase
                end else if (r_left != '0) begin
                    n_src  = r_src + IDX_W'(1);
                    n_dst  = r_src;
                    n_left = r_left - CNT_W'(1);
                    n_mv_v = 1'b1;
                end else begin
                    n_mv_v   = 1'b0;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end
            end

            S_FIN: begin
                n_count      = fin_count;
                n_out_valid  = 1'b1;
                n_out_status = r_status;
                n_out_found  = r_found;
                n_out_count  = COUNT_W'(fin_count);
                n_out_full   = (CMP_W'(fin_count) >= eff_cap);
                n_out_empty  = (fin_count == '0);
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mv_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mv_v      <= n_mv_v;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_left       <= n_left;
        r_up         <= n_up;
        r_status     <= n_status;
        r_found      <= n_found;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
        r_out_full   <= n_out_full;
        r_out_empty  <= n_out_empty;
    end

    // result word
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.found_payload = r_out_found;
    assign o_rsp.entry_count   = r_out_count;
    assign o_rsp.is_full       = r_out_full;
    assign o_rsp.is_empty      = r_out_empty;

`ifndef SYNTHESIS
    // count never exceeds the built depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(MAX_ENTRIES) >= r_count)
        else $error("entry count above depth");

    // a result is only loaded into an empty output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_out_valid)
        else $error("result overwritten");

    // a full status is always reported with the full flag
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> r_out_full)
        else $error("full status without full flag");

    // a new command is only taken while the sequencer is idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != S_IDLE))
        else $error("command popped but sequencer idle");
`endif
endmodule
`default_nettype wire

@@ src/keyed_unordered_list_table_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_unordered_list_table_core: bounded unordered key/payload list
// Packed list of up to MAX_ENTRIES entries with insert, remove, find and
// update by key.
// ---------------------------------------------------------------------------
// Usage:
//   i_req  - request words (mode, entry_key, entry_payload), valid/ready.
//   o_rsp  - one result word per request (status, found_payload,
//            entry_count, is_full, is_empty), valid/ready.
//   i_cfg  - capacity limit writes; always ready. Write only while idle.
// Sequencing: insert back, remove last, no-op and refused requests go
//   straight to the result; insert front and remove first shift the stored
//   entries, a find or update searches up to the match, a remove by key hit
//   searches and then closes the gap above the match, and any key miss
//   searches every entry. The back end walks one entry a cycle and takes
//   one request at a time, so it starts no request before the last is done.
// Reset: count clears, capacity limit returns to 16; stores are not cleared.
// Stall: the result register holds while o_rsp.ready is low; the queue
//   keeps taking up to two requests meanwhile, then i_req.ready drops.
// ---------------------------------------------------------------------------
module keyed_unordered_list_table_core #(
    parameter int MAX_ENTRIES = kul_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kul_req_if.sink   i_req,
    kul_rsp_if.source o_rsp,
    kul_cfg_if.sink   i_cfg
);
    import kul_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             push;
    logic             q_full;
    t_cmd             push_cmd;
    logic             q_valid;
    t_cmd             q_cmd;
    logic             q_pop;

    // capacity limit register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.capacity_limit;
        end
    end

    kul_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    kul_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    kul_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_rsp      (o_rsp)
    );
endmodule
`default_nettype wire
